@@ rtl/pcca_pkg.sv @@
// Shared constants, codes and control structs of the centroid accumulator.
`default_nettype none

package pcca_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int VECTOR_LEN  = 1024;
    localparam int MAX_SAMPLES = 65536;

    localparam int FUNC_W  = 2;
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int POS_W   = $clog2(VECTOR_LEN);
    localparam int VAL_W   = 8;
    localparam int ADDR_W  = CLS_W + POS_W;
    localparam int DEPTH   = NUM_CLASSES * VECTOR_LEN;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int MEAN_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int STEP_W  = $clog2(MEAN_W);

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SAMPLES);
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ACC   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    typedef struct packed {
        logic clr_cnt;   // clear request taken: zero the counts
        logic sweep;     // write one zero entry of the sum store
        logic acc;       // accumulate request taken
        logic rd_start;  // read request taken
        logic div_load;  // sum data back from the store
        logic div_step;  // one quotient bit
        logic out_load;  // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic rd_direct;  // empty class or saturated mean, no division
        logic div_last;
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/pcca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module pcca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/pcca_ctrl.sv @@
// Controller state machine: request intake, clearing sweep, read and divide sequence.
`default_nettype none

module pcca_ctrl
    import pcca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [FUNC_W-1:0] i_func,
    output logic                   o_ready,
    output t_cmd                   o_cmd,
    input  wire t_status           i_st
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDMEM = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign o_ready = (r_state == S_IDLE);
    assign w_take  = o_ready && i_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    case (i_func)
                        FN_CLEAR: begin
                            o_cmd.clr_cnt = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        FN_ACC: begin
                            o_cmd.acc = 1'b1;
                        end
                        FN_READ: begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_RDMEM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDMEM: begin
                o_cmd.div_load = 1'b1;
                n_state        = i_st.rd_direct ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_st.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pcca_dp.sv @@
// Datapath: sum store with read-modify-write, counts, serial divider, output register.
`default_nettype none

module pcca_dp
    import pcca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_st,
    input  wire logic [CLS_W-1:0]  i_cls,
    input  wire logic [POS_W-1:0]  i_pos,
    input  wire logic [VAL_W-1:0]  i_val,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [MEAN_W-1:0]      o_mean,
    output logic                   o_empty
);

    logic [CNT_W-1:0]  r_cnt [NUM_CLASSES];

    logic              r_acc_vld;
    logic [ADDR_W-1:0] r_addr_q;
    logic [VAL_W-1:0]  r_acc_val;
    logic [ADDR_W-1:0] r_sweep_addr;

    logic              r_wr_vld;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [SUM_W-1:0]  r_wr_data;

    logic [CNT_W-1:0]  r_rd_cnt;
    logic [CNT_W:0]    r_rem;
    logic [MEAN_W-1:0] r_dlow;
    logic [MEAN_W-1:0] r_quot;
    logic [STEP_W-1:0] r_step;

    logic              r_out_vld;
    logic [MEAN_W-1:0] r_out_mean;
    logic              r_out_empty;

    logic [ADDR_W-1:0] w_in_addr;
    logic [SUM_W-1:0]  w_ram_q;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W:0]    w_add;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [SUM_W-1:0]  w_wdata;
    logic              w_empty;
    logic              w_sat;
    logic [CNT_W+1:0]  w_trial;
    logic              w_ge;

    assign w_in_addr = {i_cls, i_pos};

    pcca_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_in_addr),
        .o_rdata (w_ram_q)
    );

    // the write that landed at the same edge as the read is not in the read data
    assign w_sum = (r_wr_vld && (r_wr_addr == r_addr_q)) ? r_wr_data : w_ram_q;
    assign w_add = {1'b0, w_sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, r_acc_val};

    always_comb begin
        w_we    = r_acc_vld || i_cmd.sweep;
        w_waddr = r_acc_vld ? r_addr_q : r_sweep_addr;
        w_wdata = '0;
        if (r_acc_vld) begin
            w_wdata = w_add[SUM_W] ? SUM_MAX : w_add[SUM_W-1:0];
        end
    end

    assign w_empty = (r_rd_cnt == '0);
    assign w_sat   = ({1'b0, w_sum} >= {r_rd_cnt, {FRAC_W{1'b0}}});
    assign w_trial = {r_rem, r_dlow[MEAN_W-1]};
    assign w_ge    = (w_trial >= {2'b00, r_rd_cnt});

    assign o_st.sweep_last = i_cmd.sweep && (r_sweep_addr == ADDR_W'(DEPTH - 1));
    assign o_st.rd_direct  = w_empty || w_sat;
    assign o_st.div_last   = (r_step == '0);
    assign o_st.out_full   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
            end
            r_acc_vld    <= 1'b0;
            r_wr_vld     <= 1'b0;
            r_sweep_addr <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    r_cnt[k] <= '0;
                end
            end else if (i_cmd.acc && (i_pos == '0) && (r_cnt[i_cls] < CNT_MAX)) begin
                r_cnt[i_cls] <= r_cnt[i_cls] + 1'b1;
            end
            r_acc_vld <= i_cmd.acc;
            r_wr_vld  <= w_we;
            if (i_cmd.sweep) begin
                r_sweep_addr <= (r_sweep_addr == ADDR_W'(DEPTH - 1)) ? '0
                                                                     : r_sweep_addr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc || i_cmd.rd_start) begin
            r_addr_q <= w_in_addr;
        end
        r_acc_val <= i_val;
        r_wr_addr <= w_waddr;
        r_wr_data <= w_wdata;
        if (i_cmd.rd_start) begin
            r_rd_cnt <= r_cnt[i_cls];
        end
        if (i_cmd.div_load) begin
            r_rem  <= {{(CNT_W + 1 - (SUM_W - FRAC_W)){1'b0}}, w_sum[SUM_W-1:FRAC_W]};
            r_dlow <= {w_sum[FRAC_W-1:0], {(MEAN_W - FRAC_W){1'b0}}};
            r_step <= STEP_W'(MEAN_W - 1);
            r_quot <= w_empty ? '0 : MEAN_MAX;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? (CNT_W + 1)'(w_trial - {2'b00, r_rd_cnt}) : w_trial[CNT_W:0];
            r_dlow <= {r_dlow[MEAN_W-2:0], 1'b0};
            r_quot <= {r_quot[MEAN_W-2:0], w_ge};
            r_step <= r_step - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_mean  <= r_quot;
            r_out_empty <= w_empty;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_mean      = r_out_mean;
    assign o_empty     = r_out_empty;

endmodule

`default_nettype wire

@@ rtl/per_class_centroid_accumulator_core.sv @@
// Top level of the k-means centroid accumulator: controller, datapath, checks.
//
//  channel  | dir | tdata                               | tuser
//  ---------+-----+-------------------------------------+------------------
//  s_axis   | in  | class_index, pixel_index, pixel_val | func
//  m_axis   | out | mean_value (Q8.8)                   | class_empty
//
// Accumulate requests stream back to back through a read-modify-write on the sum
// RAM with a one-deep write forward.
// A clear request sweeps the 16384-entry sum RAM, one entry a cycle, before the
// next request is taken; reset starts the same sweep.
// A read request fetches the sum, then runs the bit-serial divider (empty class or
// saturated mean skips the divider); a full output register holds off the next request.
`default_nettype none

module per_class_centroid_accumulator_core
    import pcca_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // class_index[3:0], pixel_index[13:4],
                                             // pixel_value[21:14], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // mean_value[15:0]
    output logic             m_axis_tuser    // class_empty
);

    t_cmd    w_cmd;
    t_status w_st;

    pcca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd),
        .i_st    (w_st)
    );

    pcca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_cls       (s_axis_tdata[CLS_W-1:0]),
        .i_pos       (s_axis_tdata[CLS_W+POS_W-1:CLS_W]),
        .i_val       (s_axis_tdata[CLS_W+POS_W+VAL_W-1:CLS_W+POS_W]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_mean      (m_axis_tdata),
        .o_empty     (m_axis_tuser)
    );

    a_sweep_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep |-> !s_axis_tready)
        else $error("request taken during clearing sweep");

    a_read_fetches_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_start |=> w_cmd.div_load)
        else $error("read request not followed by sum fetch");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !m_axis_tvalid)
        else $error("result loaded over a pending one");

    a_acc_no_sweep_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.acc |=> !w_cmd.sweep)
        else $error("sweep write collides with accumulate write");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the k-means centroid accumulator core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcca_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int  CLK_HALF    = 6;
    localparam int  LIMIT_NS    = 48_000_000;  // far above the slowest run
    localparam int  TAIL_CYCLES = 40;          // longest read latency plus margin
    localparam int  RAND_ITEMS  = 1150;
    localparam int  SAT_PIXELS  = 60;          // pixels at one position, no sample start
    localparam int  SAT_SAMPLES = 20;          // too few samples: mean above Q8.8

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              empty;
    } t_mean_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;   // class_index[3:0], pixel_index[13:4],
                                       // pixel_value[21:14], zero pad
    logic [1:0]        s_axis_tuser;   // func[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // mean_value[15:0]
    logic              m_axis_tuser;   // class_empty

    // centroid model
    logic [SUM_W-1:0]  model_sums   [DEPTH];
    logic [CNT_W-1:0]  model_counts [NUM_CLASSES];
    t_mean_result      expected_means[$];

    int error_count   = 0;
    int rx_hold_left  = 0;
    int tx_burst_left = 0;
    bit tx_gaps_on    = 0;

    per_class_centroid_accumulator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #(CLK_HALF);
        i_clk = 1'b0;
        #(CLK_HALF);
    end

    task automatic report_mismatch(input string what);
        if (error_count < 50) begin
            $display("ERROR @%0t: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic void clear_centroids();
        foreach (model_sums[i]) model_sums[i] = '0;
        foreach (model_counts[i]) model_counts[i] = '0;
    endfunction

    function automatic t_mean_result centroid_mean(input logic [CLS_W-1:0] cls,
                                                   input logic [POS_W-1:0] pos);
        t_mean_result      r;
        logic [CNT_W-1:0]  cnt;
        longint unsigned   q;
        cnt     = model_counts[cls];
        r.empty = (cnt == '0);
        r.mean  = '0;
        if (cnt != '0) begin
            q = (longint'(model_sums[{cls, pos}]) << FRAC_W) / longint'(cnt);
            r.mean = (q > longint'(MEAN_MAX)) ? MEAN_MAX : q[MEAN_W-1:0];
        end
        return r;
    endfunction

    function automatic void update_centroids(input logic [FUNC_W-1:0] fn,
                                             input logic [CLS_W-1:0]  cls,
                                             input logic [POS_W-1:0]  pos,
                                             input logic [VAL_W-1:0]  val);
        logic [SUM_W:0] next_sum;
        case (fn)
            FN_CLEAR: clear_centroids();
            FN_ACC: begin
                if (pos == '0 && model_counts[cls] < CNT_MAX) begin
                    model_counts[cls] = model_counts[cls] + 1'b1;
                end
                next_sum = {1'b0, model_sums[{cls, pos}]} + val;
                model_sums[{cls, pos}] = (next_sum > SUM_MAX) ? SUM_MAX : next_sum[SUM_W-1:0];
            end
            FN_READ: expected_means.push_back(centroid_mean(cls, pos));
            default: ;  // unused code: no effect
        endcase
    endfunction

    // Outputs are checked before the request of the same edge updates the model.
    always @(posedge i_clk) begin
        t_mean_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("unexpected result mean=%0d empty=%0d",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_means.pop_front();
                if (m_axis_tdata !== want.mean) begin
                    report_mismatch($sformatf("mean_value %0d, expected %0d",
                                              m_axis_tdata, want.mean));
                end
                if (m_axis_tuser !== want.empty) begin
                    report_mismatch($sformatf("class_empty %0d, expected %0d",
                                              m_axis_tuser, want.empty));
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            update_centroids(s_axis_tuser,
                             s_axis_tdata[CLS_W-1:0],
                             s_axis_tdata[CLS_W+POS_W-1:CLS_W],
                             s_axis_tdata[CLS_W+POS_W+VAL_W-1:CLS_W+POS_W]);
        end
    end

    // Receiver: a long hold-off when requested, else random stall phases.
    initial begin
        int               rx_mode;
        int               rx_phase_left;
        logic [15:0]      rx_pattern;
        rx_mode       = 0;
        rx_phase_left = 0;
        rx_pattern    = '1;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(20, 200);
                    rx_pattern    = 16'($urandom);
                end
                rx_phase_left--;
                rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= rx_pattern[0];
                    2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic sender_idle(input int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] fn,
                                input logic [CLS_W-1:0]  cls,
                                input logic [POS_W-1:0]  pos,
                                input logic [VAL_W-1:0]  val);
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                sender_idle($urandom_range(1, 12));
                tx_burst_left = $urandom_range(1, 24);
            end
            tx_burst_left--;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, pos, cls};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic wait_drained();
        sender_idle(1);
        while (expected_means.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_request(FN_READ, '0, '0, '0);
        send_request(FN_READ, CLS_W'(NUM_CLASSES - 1), POS_W'(VECTOR_LEN - 1), 8'hFF);
        send_request(FN_UNUSED, 4'd3, '0, 8'hFF);   // must not count a sample
        send_request(FN_READ, 4'd3, '0, '0);
        wait_drained();
    endtask

    task automatic test_directed();
        send_request(FN_ACC,  '0, '0, 8'hFF);
        send_request(FN_ACC,  '0, POS_W'(VECTOR_LEN - 1), 8'hFF);
        send_request(FN_ACC,  '0, POS_W'(VECTOR_LEN - 1), 8'hFF);  // mean above Q8.8 range
        send_request(FN_READ, '0, '0, '0);
        send_request(FN_READ, '0, POS_W'(VECTOR_LEN - 1), '0);
        send_request(FN_READ, '0, 10'd512, '0);                    // untouched position
        send_request(FN_ACC,  4'd15, '0, 8'd1);
        send_request(FN_ACC,  4'd15, '0, 8'd0);
        send_request(FN_ACC,  4'd15, '0, 8'd0);
        send_request(FN_READ, 4'd15, '0, '0);                      // 256/3 truncates
        send_request(FN_ACC,  4'd15, POS_W'(VECTOR_LEN - 1), 8'd0);
        send_request(FN_READ, 4'd15, POS_W'(VECTOR_LEN - 1), '0);
        send_request(FN_UNUSED, 4'd15, '0, 8'hFF);
        send_request(FN_READ, 4'd15, '0, '0);
        send_request(FN_CLEAR, '0, '0, '0);
        send_request(FN_READ, '0, '0, '0);
        send_request(FN_READ, 4'd15, POS_W'(VECTOR_LEN - 1), '0);
        send_request(FN_ACC,  4'd7, '0, 8'd128);
        send_request(FN_READ, 4'd7, '0, '0);
        wait_drained();
    endtask

    // Output held off long enough for reads to back up into the input.
    task automatic test_backpressure();
        logic [CLS_W-1:0] cls;
        rx_hold_left = 300;
        for (int i = 0; i < 40; i++) begin
            cls = CLS_W'($urandom_range(0, NUM_CLASSES - 1));
            if (i % 4 == 0) send_request(FN_ACC, cls, '0, VAL_W'($urandom_range(0, 255)));
            send_request(FN_READ, cls, POS_W'($urandom_range(0, 3)), '0);
        end
        wait_drained();
    endtask

    // Mostly well-formed feature vectors, reads of recent positions, some noise.
    task automatic test_random_traffic();
        int               sent;
        int               roll;
        int               len;
        logic [3:0]       hist_wr;
        logic [POS_W-1:0] pos_hist [16];
        logic [CLS_W-1:0] cls;
        logic [POS_W-1:0] pos;
        sent    = 0;
        hist_wr = '0;
        foreach (pos_hist[i]) pos_hist[i] = '0;
        tx_gaps_on = 1;
        while (sent < RAND_ITEMS) begin
            roll = $urandom_range(0, 99);
            cls  = CLS_W'($urandom_range(0, NUM_CLASSES - 1));
            if (roll < 60) begin
                send_request(FN_ACC, cls, '0, VAL_W'($urandom_range(0, 255)));
                len = $urandom_range(1, 8);
                for (int k = 1; k <= len; k++) begin
                    if ($urandom_range(0, 9) == 0) pos = pos_hist[hist_wr - 4'd1];
                    else if ($urandom_range(0, 1)) pos = POS_W'(k);
                    else pos = POS_W'($urandom_range(1, VECTOR_LEN - 1));
                    pos_hist[hist_wr] = pos;
                    hist_wr = hist_wr + 4'd1;
                    send_request(FN_ACC, cls, pos, VAL_W'($urandom_range(0, 255)));
                end
                sent += len + 1;
            end else if (roll < 85) begin
                if ($urandom_range(0, 9) < 7) pos = pos_hist[4'($urandom_range(0, 15))];
                else pos = POS_W'($urandom_range(0, VECTOR_LEN - 1));
                send_request(FN_READ, cls, pos, VAL_W'($urandom_range(0, 255)));
                sent++;
            end else if (roll < 95) begin
                send_request(FN_UNUSED, cls, POS_W'($urandom_range(0, VECTOR_LEN - 1)),
                             VAL_W'($urandom_range(0, 255)));
                sent++;
            end else if (roll < 99) begin
                // pixel at a random position, mostly with no sample start
                send_request(FN_ACC, cls, POS_W'($urandom_range(0, VECTOR_LEN - 1)),
                             VAL_W'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_request(FN_CLEAR, cls, POS_W'($urandom_range(0, VECTOR_LEN - 1)),
                             VAL_W'($urandom_range(0, 255)));
                sent++;
            end
        end
        tx_gaps_on = 0;
        wait_drained();
    endtask

    // One position of one class driven past the Q8.8 mean limit.
    task automatic test_saturation();
        send_request(FN_CLEAR, '0, '0, '0);
        for (int i = 0; i < SAT_PIXELS; i++) send_request(FN_ACC, 4'd9, 10'd2, 8'hFF);
        send_request(FN_READ, 4'd9, 10'd2, '0);      // sum present, class still empty
        for (int i = 0; i < SAT_SAMPLES; i++) begin
            send_request(FN_ACC, 4'd9, '0, 8'hFF);
            if (i % 8 == 7) send_request(FN_READ, 4'd9, 10'd2, '0);
        end
        send_request(FN_READ, 4'd9, '0, '0);
        send_request(FN_READ, 4'd9, 10'd2, '0);
        send_request(FN_READ, 4'd9, 10'd1, '0);
        send_request(FN_CLEAR, '0, '0, '0);
        send_request(FN_READ, 4'd9, '0, '0);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        clear_centroids();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_backpressure();
        test_random_traffic();
        test_saturation();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS per_class_centroid_accumulator_core");
        end else begin
            $display("FAIL per_class_centroid_accumulator_core");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL per_class_centroid_accumulator_core");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/pcca_pkg.sv
rtl/pcca_ram.sv
rtl/pcca_ctrl.sv
rtl/pcca_dp.sv
rtl/per_class_centroid_accumulator_core.sv
dv/tb.sv
